### rtl/core/bba_pkg.sv
package bba_pkg;

  // Result codes
  typedef enum logic [2:0] {
    ST_ALLOC   = 3'd0,
    ST_FREED   = 3'd1,
    ST_IGNORED = 3'd2,
    ST_ZERO    = 3'd3,
    ST_SHORT   = 3'd4,
    ST_NOBLK   = 3'd5
  } status_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_CLEAR   = 4'd1,
    OP_EVAL    = 4'd2,
    OP_SCAN    = 4'd3,
    OP_TAKE    = 4'd4,
    OP_UNLINK  = 4'd5,
    OP_SPLIT   = 4'd6,
    OP_GRANT   = 4'd7,
    OP_RELEASE = 4'd8,
    OP_PROBE   = 4'd9,
    OP_MERGE   = 4'd10,
    OP_PUSH    = 4'd11
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;   // latch the accepted request beat
    logic emit;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic reject;
    logic clear_done;
    logic lvl_found;
    logic scan_end;
    logic split_more;
    logic use_ok;
    logic at_top;
    logic can_merge;
    logic out_full;
  } sts_t;

endpackage

### rtl/core/buddy_block_allocator.sv
// Channel | Signals                                  | Direction | Beat moves when
// req     | req_valid, req_stall, func, request_size,| in        | req_valid && !req_stall
//         | address                                  |           |
// rsp     | rsp_valid, rsp_stall, address_out,       | out       | rsp_valid && !rsp_stall
//         | status, free_bytes                       |           |
// cfg     | cfg_valid, cfg_ready, cfg_data           | in        | cfg_valid && cfg_ready
//
// One request at a time: a new beat is taken only after the last result has been emitted.
// A rejected request goes straight to the result. An allocation scans up the levels, takes
// and unlinks a block, splits it down to the wanted level and grants it, or ends when the
// scan finds no block; a free, if the block is in use, merges free buddies up and pushes it.
// After reset a clearing pass writes one slot entry per cycle over all 2^(HEAP_LOG2-MIN_LOG2)
// slots with req_stall high; a stalled result holds in the output register.
module buddy_block_allocator #(
  parameter int HEAP_LOG2 = 16,
  parameter int MIN_LOG2  = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        func,
  input  logic [15:0] request_size,
  input  logic [15:0] address,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] address_out,
  output logic [2:0]  status,
  output logic [16:0] free_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Header size may be written at any time; the block does not check that it is idle then.
  assign cfg_ready = 1'b1;

  // Sequence split, merge and list updates
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  // Hold slot stores, level lists, free count and the output register
  bba_datapath #(
    .HEAP_LOG2 (HEAP_LOG2),
    .MIN_LOG2  (MIN_LOG2)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .request_size (request_size),
    .address      (address),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .rsp_stall    (rsp_stall),
    .rsp_valid    (rsp_valid),
    .address_out  (address_out),
    .status       (status),
    .free_bytes   (free_bytes)
  );

  // Reset always starts the clearing pass, so no beat is taken right after it.
  assert property (@(posedge clk) rst |=> req_stall)
    else $error("request taken right after reset");

  // One request in flight: an accepted beat closes the input for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken back to back");

  // Only a granted allocation carries an address.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_ALLOC) |-> (address_out == 16'd0))
    else $error("address on a result that is not a grant");

endmodule

### rtl/core/bba_ctrl.sv
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd,
  output logic          req_stall
);
  import bba_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_EVAL    = 13'b0000000000100,
    S_SCAN    = 13'b0000000001000,
    S_TAKE    = 13'b0000000010000,
    S_UNLINK  = 13'b0000000100000,
    S_SPLIT   = 13'b0000001000000,
    S_GRANT   = 13'b0000010000000,
    S_RELEASE = 13'b0000100000000,
    S_PROBE   = 13'b0001000000000,
    S_MERGE   = 13'b0010000000000,
    S_PUSH    = 13'b0100000000000,
    S_EMIT    = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.op = OP_EVAL;
        if (sts.reject) state_next = S_EMIT;
        else if (sts.is_free) state_next = S_RELEASE;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.lvl_found) state_next = S_TAKE;
        else if (sts.scan_end) state_next = S_EMIT;
      end
      S_TAKE: begin
        cmd.op     = OP_TAKE;
        state_next = S_UNLINK;
      end
      S_UNLINK: begin
        cmd.op     = OP_UNLINK;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.op = OP_SPLIT;
        if (!sts.split_more) state_next = S_GRANT;
      end
      S_GRANT: begin
        cmd.op     = OP_GRANT;
        state_next = S_EMIT;
      end
      S_RELEASE: begin
        cmd.op     = OP_RELEASE;
        state_next = sts.use_ok ? S_PROBE : S_EMIT;
      end
      S_PROBE: begin
        cmd.op     = OP_PROBE;
        state_next = sts.at_top ? S_PUSH : S_MERGE;
      end
      S_MERGE: begin
        cmd.op     = OP_MERGE;
        state_next = sts.can_merge ? S_PROBE : S_PUSH;
      end
      S_PUSH: begin
        cmd.op     = OP_PUSH;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

### rtl/core/bba_datapath.sv
module bba_datapath #(
  parameter int HEAP_LOG2 = 16,
  parameter int MIN_LOG2  = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  bba_pkg::cmd_t cmd,
  output bba_pkg::sts_t sts,
  input  logic          func,
  input  logic [15:0]   request_size,
  input  logic [15:0]   address,
  input  logic          cfg_valid,
  input  logic [5:0]    cfg_data,
  input  logic          rsp_stall,
  output logic          rsp_valid,
  output logic [15:0]   address_out,
  output logic [2:0]    status,
  output logic [16:0]   free_bytes
);
  import bba_pkg::*;

  localparam int SB    = HEAP_LOG2 - MIN_LOG2;
  localparam int NSLOT = 1 << SB;
  localparam int NLEV  = SB + 1;
  localparam int TOP   = NLEV - 1;
  localparam int LW    = $clog2(NLEV + 1);
  localparam int FW    = HEAP_LOG2 + 1;
  localparam int CW    = (FW > 17) ? FW : 17;
  localparam int AW    = (HEAP_LOG2 > 16) ? HEAP_LOG2 : 16;

  // Item and working registers
  logic [5:0]    hdr;
  logic          func_r;
  logic [15:0]   req_r, addr_r, aout;
  logic [SB-1:0] s, clr;
  logic [LW-1:0] p, want, lv;
  status_t       code;
  logic [FW-1:0] free;

  // Per-level list ends
  logic [SB-1:0]   head [NLEV];
  logic [SB-1:0]   tail [NLEV];
  logic [NLEV-1:0] nonempty;

  // Slot stores
  logic          use_mem  [NSLOT];
  logic [LW-1:0] lvl_mem  [NSLOT];
  logic [SB-1:0] prev_mem [NSLOT];
  logic [SB-1:0] next_mem [NSLOT];
  logic          use_rd;
  logic [LW-1:0] lvl_rd;
  logic [SB-1:0] prev_rd, next_rd;

  logic [SB-1:0] raddr;
  logic          use_we, lvl_we, prev_we, next_we;
  logic [SB-1:0] use_wa, lvl_wa, prev_wa, next_wa;
  logic          use_wd;
  logic [LW-1:0] lvl_wd;
  logic [SB-1:0] prev_wd, next_wd;

  logic [16:0]   total;
  logic [4:0]    fl;
  logic          notpow2;
  logic [5:0]    want_w;
  logic [15:0]   off;
  logic          bad_free;
  logic [SB-1:0] slot_of_off, b, bud, sn;
  logic [LW-1:0] pm, lv_cap;
  logic [FW-1:0] blk_take, blk_give;
  logic [AW-1:0] aout_sum;
  logic [CW-1:0] free_ext;

  assign total   = {1'b0, req_r} + {11'd0, hdr};
  assign notpow2 = |(total & (total - 17'd1));

  always_comb begin
    fl = '0;
    for (int i = 0; i < 17; i++) begin
      if (total[i]) fl = 5'(i);
    end
  end

  always_comb begin
    if (32'(fl) < MIN_LOG2) want_w = '0;
    else want_w = 6'(32'(fl) - MIN_LOG2) + {5'd0, notpow2};
  end

  assign off         = addr_r - {10'd0, hdr};
  assign bad_free    = (addr_r == 16'd0) || (addr_r < {10'd0, hdr}) ||
                       (off[MIN_LOG2-1:0] != '0) ||
                       ((AW'(off) >> HEAP_LOG2) != '0);
  assign slot_of_off = SB'(off >> MIN_LOG2);

  assign pm       = p - LW'(1);
  assign b        = s ^ (SB'(1) << pm);
  assign bud      = s ^ (SB'(1) << lv);
  assign sn       = s & ~(SB'(1) << lv);
  assign lv_cap   = (32'(lvl_rd) > TOP) ? LW'(TOP) : lvl_rd;
  assign blk_take = FW'(1) << (32'(want) + MIN_LOG2);
  assign blk_give = FW'(1) << (32'(lv_cap) + MIN_LOG2);
  assign aout_sum = (AW'(s) << MIN_LOG2) + AW'(hdr);
  assign free_ext = CW'(free);

  always_comb begin
    sts.is_free    = func_r;
    sts.reject     = func_r ? bad_free
                            : ((req_r == 16'd0) || (CW'(total) > free_ext) ||
                               (32'(want_w) >= NLEV));
    sts.clear_done = &clr;
    sts.lvl_found  = nonempty[p];
    sts.scan_end   = (p == LW'(TOP));
    sts.split_more = (p != want);
    sts.use_ok     = use_rd;
    sts.at_top     = (lv == LW'(TOP));
    sts.can_merge  = !use_rd && (lvl_rd == lv);
    sts.out_full   = rsp_valid && rsp_stall;
  end

  // Memory read address and write ports
  always_comb begin
    case (cmd.op)
      OP_EVAL:  raddr = slot_of_off;
      OP_TAKE:  raddr = tail[p];
      OP_PROBE: raddr = bud;
      default:  raddr = s;
    endcase
  end

  always_comb begin
    use_we  = 1'b0;  use_wa  = s;  use_wd  = 1'b0;
    lvl_we  = 1'b0;  lvl_wa  = s;  lvl_wd  = '0;
    prev_we = 1'b0;  prev_wa = s;  prev_wd = '0;
    next_we = 1'b0;  next_wa = s;  next_wd = '0;
    case (cmd.op)
      OP_CLEAR: begin
        use_we = 1'b1;  use_wa = clr;
        lvl_we = 1'b1;  lvl_wa = clr;
        lvl_wd = (clr == '0) ? LW'(TOP) : '0;
      end
      OP_SPLIT: begin
        if (p != want) begin
          use_we = 1'b1;  use_wa = b;
          lvl_we = 1'b1;  lvl_wa = b;  lvl_wd = pm;
          if (nonempty[pm]) begin
            prev_we = 1'b1;  prev_wa = b;         prev_wd = tail[pm];
            next_we = 1'b1;  next_wa = tail[pm];  next_wd = b;
          end
        end
      end
      OP_GRANT: begin
        use_we = 1'b1;  use_wd = 1'b1;
        lvl_we = 1'b1;  lvl_wd = want;
      end
      OP_RELEASE: begin
        use_we = use_rd;
      end
      OP_MERGE: begin
        if (sts.can_merge) begin
          lvl_we = 1'b1;  lvl_wa = sn;  lvl_wd = lv + LW'(1);
          if (nonempty[lv] && head[lv] != bud && tail[lv] != bud) begin
            next_we = 1'b1;  next_wa = prev_rd;  next_wd = next_rd;
            prev_we = 1'b1;  prev_wa = next_rd;  prev_wd = prev_rd;
          end
        end
      end
      OP_PUSH: begin
        if (nonempty[lv]) begin
          next_we = 1'b1;  next_wa = tail[lv];  next_wd = s;
          prev_we = 1'b1;  prev_wa = s;         prev_wd = tail[lv];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (use_we) use_mem[use_wa] <= use_wd;
    use_rd <= use_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    lvl_rd <= lvl_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr       <= 6'd24;
      nonempty  <= {1'b1, {(NLEV-1){1'b0}}};
      for (int i = 0; i < NLEV; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
      free      <= FW'(1) << HEAP_LOG2;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) hdr <= cfg_data;

      if (cmd.emit) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;

      if (cmd.load) begin
        func_r <= func;
        req_r  <= request_size;
        addr_r <= address;
        aout   <= '0;
      end

      if (cmd.emit) begin
        address_out <= aout;
        status      <= code;
        free_bytes  <= free_ext[16:0];
      end

      case (cmd.op)
        OP_CLEAR: clr <= clr + SB'(1);
        OP_EVAL: begin
          p    <= LW'(want_w);
          want <= LW'(want_w);
          s    <= slot_of_off;
          if (func_r) code <= ST_IGNORED;
          else if (req_r == 16'd0) code <= ST_ZERO;
          else if (CW'(total) > free_ext) code <= ST_SHORT;
          else code <= ST_NOBLK;
        end
        OP_SCAN: begin
          if (!nonempty[p] && p != LW'(TOP)) p <= p + LW'(1);
        end
        OP_TAKE: s <= tail[p];
        OP_UNLINK: begin
          if (head[p] == s) nonempty[p] <= 1'b0;
          else tail[p] <= prev_rd;
        end
        OP_SPLIT: begin
          if (p != want) begin
            p <= pm;
            tail[pm] <= b;
            if (!nonempty[pm]) begin
              head[pm]     <= b;
              nonempty[pm] <= 1'b1;
            end
          end
        end
        OP_GRANT: begin
          free <= free - blk_take;
          aout <= aout_sum[15:0];
          code <= ST_ALLOC;
        end
        OP_RELEASE: begin
          if (use_rd) begin
            lv   <= lv_cap;
            free <= free + blk_give;
          end
        end
        OP_MERGE: begin
          if (sts.can_merge) begin
            if (nonempty[lv]) begin
              if (head[lv] == bud && tail[lv] == bud) nonempty[lv] <= 1'b0;
              else if (head[lv] == bud) head[lv] <= next_rd;
              else if (tail[lv] == bud) tail[lv] <= prev_rd;
            end
            s  <= sn;
            lv <= lv + LW'(1);
          end
        end
        OP_PUSH: begin
          tail[lv] <= s;
          if (!nonempty[lv]) begin
            head[lv]     <= s;
            nonempty[lv] <= 1'b1;
          end
          code <= ST_FREED;
        end
        default: ;
      endcase
    end
  end

endmodule
